>>> design/s16c_pkg.sv
package s16c_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned MEM_DEPTH = 65536;
  localparam logic [15:0] INSN_BYTES = 16'd5;
  localparam logic [15:0] FIRST_RAM_REG = 16'd3;
  localparam logic [15:0] SP_RESET = 16'hFFFF;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_REG   = 2'd2;
  localparam logic [1:0] CMD_RUN   = 2'd3;

  localparam logic [15:0] IDX_PC    = 16'd0;
  localparam logic [15:0] IDX_SP    = 16'd1;
  localparam logic [15:0] IDX_FLAGS = 16'd2;

  localparam int unsigned FLAG_Z   = 0;
  localparam int unsigned FLAG_C   = 1;
  localparam int unsigned FLAG_S   = 2;
  localparam int unsigned FLAG_REL = 4;

  localparam logic [7:0] OP_LDI  = 8'd0;
  localparam logic [7:0] OP_MOV  = 8'd1;
  localparam logic [7:0] OP_LD   = 8'd2;
  localparam logic [7:0] OP_STR  = 8'd3;
  localparam logic [7:0] OP_RLD  = 8'd4;
  localparam logic [7:0] OP_RSTR = 8'd5;
  localparam logic [7:0] OP_XCHG = 8'd6;
  localparam logic [7:0] OP_PSH  = 8'd7;
  localparam logic [7:0] OP_PSHI = 8'd8;
  localparam logic [7:0] OP_POP  = 8'd9;
  localparam logic [7:0] OP_PEK  = 8'd10;
  localparam logic [7:0] OP_SRMV = 8'd11;
  localparam logic [7:0] OP_SWP  = 8'd12;
  localparam logic [7:0] OP_LEA  = 8'd13;
  localparam logic [7:0] OP_ADD  = 8'd14;
  localparam logic [7:0] OP_SUB  = 8'd15;
  localparam logic [7:0] OP_MUL  = 8'd16;
  localparam logic [7:0] OP_DIV  = 8'd17;
  localparam logic [7:0] OP_INC  = 8'd18;
  localparam logic [7:0] OP_DEC  = 8'd19;
  localparam logic [7:0] OP_AND  = 8'd20;
  localparam logic [7:0] OP_OR   = 8'd21;
  localparam logic [7:0] OP_NOT  = 8'd22;
  localparam logic [7:0] OP_XOR  = 8'd23;
  localparam logic [7:0] OP_SHL  = 8'd24;
  localparam logic [7:0] OP_SHR  = 8'd25;
  localparam logic [7:0] OP_RSL  = 8'd26;
  localparam logic [7:0] OP_RSR  = 8'd27;
  localparam logic [7:0] OP_CMP  = 8'd28;
  localparam logic [7:0] OP_JMP  = 8'd29;
  localparam logic [7:0] OP_JZ   = 8'd30;
  localparam logic [7:0] OP_JNZ  = 8'd31;
  localparam logic [7:0] OP_JGT  = 8'd32;
  localparam logic [7:0] OP_JLT  = 8'd33;
  localparam logic [7:0] OP_JGE  = 8'd34;
  localparam logic [7:0] OP_JLE  = 8'd35;
  localparam logic [7:0] OP_CALL = 8'd36;
  localparam logic [7:0] OP_RET  = 8'd38;
  localparam logic [7:0] OP_HLT  = 8'd40;
  localparam logic [7:0] OP_WAIT = 8'd41;
  localparam logic [7:0] OP_WAITI = 8'd42;
  localparam logic [7:0] OP_TJF  = 8'd44;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] program_counter;
    logic        halted;
    logic        frozen;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MEMRD, S_REGRD, S_FETCH, S_OPA, S_OPB, S_OPC,
    S_EXEC, S_DIV, S_MRD, S_MWR, S_WB, S_WB2, S_FIN, S_DONE
  } state_e;

endpackage

>>> design/s16c_ram.sv
module s16c_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sixteen_bit_cpu_core_unit.sv
// Commands: write byte, read byte or register, run; a halted or frozen run executes nothing.
// Instruction run: fetch, operand reads, execute or divide, data byte reads/writes, write-back.
// Run time is set by the two-port byte memory (one byte per cycle) and the shared
// register-file read port; one request is in flight at a time, plus one waiting result.
// Reset: asynchronous, active low; then a clearing pass zeroes all 65536 memory bytes,
// during which no request is taken (configuration writes still are).
module sixteen_bit_cpu_core_unit #(
  parameter int unsigned GENERAL_REGS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  s16c_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output s16c_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned RF_DEPTH = 8 + GENERAL_REGS;
  localparam int unsigned RFW = $clog2(RF_DEPTH);
  localparam logic [15:0] NREGS = 16'(11 + GENERAL_REGS);

  s16c_pkg::state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] clr_q;
  logic [15:0] pc_q, sp_q, flags_q, frz_q;
  logic        halt_q;
  logic [39:0] ins_q;
  logic [15:0] va_q, vb_q, res_q, rem_q, rdw_q, rdat_q;
  logic [RF_DEPTH-1:0] rf_vld_q;
  logic [15:0] rf_idx_q;
  s16c_pkg::out_item_t out_q;
  logic        out_vld_q;

  logic [7:0]  op;
  logic [15:0] opa, opb;
  logic        acc;

  assign op  = ins_q[39:32];
  assign opa = ins_q[31:16];
  assign opb = ins_q[15:0];
  assign acc = in_valid_i && !in_stall_o;

  // memory and register file ports
  logic        mem_we;
  logic [15:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic [15:0] rf_rd_idx, rf_off, rw_off;
  logic [15:0] rf_rdata, rd_val;
  logic        rw_en, rw_ram;
  logic [15:0] rw_idx, rw_val;

  // per-opcode plan
  logic [1:0]  nrd, nwr;
  logic [15:0] rd_addr, wr_addr;
  logic [7:0]  wr_data;
  logic        wb_en;
  logic [15:0] wb_idx, wb_val, alu_res, cmp_diff, pc_fin, sp_fin, ret5, br_base;
  logic [31:0] prod;
  logic [3:0]  rot;
  logic        take;
  logic [16:0] trial;

  s16c_ram #(.WIDTH(8), .DEPTH(s16c_pkg::MEM_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  s16c_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rw_ram),
    .waddr_i (rw_off[RFW-1:0]),
    .wdata_i (rw_val),
    .raddr_i (rf_off[RFW-1:0]),
    .rdata_o (rf_rdata)
  );

  // register read value, in the cycle after the index was issued
  always_comb begin
    logic [15:0] off;
    off = rf_idx_q - s16c_pkg::FIRST_RAM_REG;
    if (rf_idx_q == s16c_pkg::IDX_PC) begin
      rd_val = pc_q;
    end else if (rf_idx_q == s16c_pkg::IDX_SP) begin
      rd_val = sp_q;
    end else if (rf_idx_q == s16c_pkg::IDX_FLAGS) begin
      rd_val = flags_q;
    end else if (rf_idx_q < NREGS && rf_vld_q[off[RFW-1:0]]) begin
      rd_val = rf_rdata;
    end else begin
      rd_val = '0;
    end
  end

  // opcode decode
  always_comb begin
    logic k;
    k = cnt_q[0];
    nrd = 2'd0;
    nwr = 2'd0;
    rd_addr = '0;
    wr_addr = '0;
    wr_data = '0;
    wb_en = 1'b0;
    wb_idx = opa;
    wb_val = '0;
    ret5 = pc_q + s16c_pkg::INSN_BYTES;
    case (op) inside
      s16c_pkg::OP_LD: begin
        nrd = 2'd2; rd_addr = opb + {15'd0, k};
        wb_en = 1'b1; wb_val = rdw_q;
      end
      s16c_pkg::OP_RLD: begin
        nrd = 2'd2; rd_addr = vb_q + {15'd0, k};
        wb_en = 1'b1; wb_val = rdw_q;
      end
      s16c_pkg::OP_POP, s16c_pkg::OP_PEK, s16c_pkg::OP_SRMV: begin
        if (op != s16c_pkg::OP_SRMV) begin
          nrd = 2'd2; wb_en = 1'b1; wb_val = rdw_q;
        end
        if (op != s16c_pkg::OP_PEK) begin
          nwr = 2'd2;
        end
        rd_addr = sp_q + 16'd1 + {15'd0, k};
        wr_addr = rd_addr;
      end
      s16c_pkg::OP_SWP: begin
        nrd = 2'd1; rd_addr = opa;
        nwr = 2'd1; wr_addr = opa; wr_data = vb_q[7:0];
        wb_en = 1'b1; wb_idx = opb; wb_val = rdw_q;
      end
      s16c_pkg::OP_RET: begin
        nrd = 2'd2; rd_addr = k ? sp_q + 16'd1 : sp_q + 16'd2;
      end
      s16c_pkg::OP_STR: begin
        nwr = 2'd2; wr_addr = opa + {15'd0, k};
        wr_data = k ? vb_q[7:0] : vb_q[15:8];
      end
      s16c_pkg::OP_RSTR: begin
        nwr = 2'd2; wr_addr = va_q + {15'd0, k};
        wr_data = k ? vb_q[7:0] : vb_q[15:8];
      end
      s16c_pkg::OP_PSH: begin
        nwr = 2'd2; wr_addr = sp_q - {15'd0, k};
        wr_data = k ? va_q[15:8] : va_q[7:0];
      end
      s16c_pkg::OP_PSHI: begin
        nwr = 2'd2; wr_addr = sp_q - {15'd0, k};
        wr_data = k ? opa[15:8] : opa[7:0];
      end
      s16c_pkg::OP_CALL: begin
        nwr = 2'd2; wr_addr = sp_q - {15'd0, k};
        wr_data = k ? ret5[7:0] : ret5[15:8];
      end
      s16c_pkg::OP_LDI, s16c_pkg::OP_LEA: begin
        wb_en = 1'b1; wb_val = opb;
      end
      s16c_pkg::OP_MOV, s16c_pkg::OP_XCHG: begin
        wb_en = 1'b1; wb_val = vb_q;
      end
      [s16c_pkg::OP_ADD:s16c_pkg::OP_RSR]: begin
        wb_en = 1'b1;
        wb_val = (op == s16c_pkg::OP_DIV && vb_q == '0) ? '0 : res_q;
      end
      default: begin
      end
    endcase
  end

  // ALU, compare, branch
  assign prod     = va_q * vb_q;
  assign rot      = vb_q[3:0];
  assign cmp_diff = va_q - vb_q;
  assign trial    = {rem_q, res_q[15]};
  assign br_base  = flags_q[s16c_pkg::FLAG_REL] ? pc_q + opa : opa;

  always_comb begin
    case (op)
      s16c_pkg::OP_ADD: alu_res = va_q + vb_q;
      s16c_pkg::OP_SUB: alu_res = cmp_diff;
      s16c_pkg::OP_MUL: alu_res = prod[15:0];
      s16c_pkg::OP_INC: alu_res = va_q + 16'd1;
      s16c_pkg::OP_DEC: alu_res = va_q - 16'd1;
      s16c_pkg::OP_AND: alu_res = va_q & vb_q;
      s16c_pkg::OP_OR:  alu_res = va_q | vb_q;
      s16c_pkg::OP_NOT: alu_res = ~va_q;
      s16c_pkg::OP_XOR: alu_res = va_q ^ vb_q;
      s16c_pkg::OP_SHL: alu_res = (vb_q >= 16'd16) ? '0 : va_q << rot;
      s16c_pkg::OP_SHR: alu_res = (vb_q >= 16'd16) ? '0 : va_q >> rot;
      s16c_pkg::OP_RSL: alu_res = (va_q << rot) | (va_q >> (5'd16 - {1'b0, rot}));
      s16c_pkg::OP_RSR: alu_res = (va_q >> rot) | (va_q << (5'd16 - {1'b0, rot}));
      default:          alu_res = va_q;  // div starts with the dividend
    endcase
  end

  always_comb begin
    logic z, s;
    z = flags_q[s16c_pkg::FLAG_Z];
    s = flags_q[s16c_pkg::FLAG_S];
    case (op)
      s16c_pkg::OP_JMP: take = 1'b1;
      s16c_pkg::OP_JZ:  take = z;
      s16c_pkg::OP_JNZ: take = !z;
      s16c_pkg::OP_JGT: take = !z && !s;
      s16c_pkg::OP_JLT: take = s;
      s16c_pkg::OP_JGE: take = !s || z;
      s16c_pkg::OP_JLE: take = s || z;
      default:          take = 1'b0;
    endcase
    case (op) inside
      s16c_pkg::OP_CALL: pc_fin = opa;
      s16c_pkg::OP_RET:  pc_fin = rdw_q;
      default:           pc_fin = take ? br_base : pc_q + s16c_pkg::INSN_BYTES;
    endcase
    case (op) inside
      s16c_pkg::OP_PSH, s16c_pkg::OP_PSHI, s16c_pkg::OP_CALL: sp_fin = sp_q - 16'd2;
      s16c_pkg::OP_POP, s16c_pkg::OP_PEK, s16c_pkg::OP_SRMV, s16c_pkg::OP_RET:
        sp_fin = sp_q + 16'd2;
      default: sp_fin = sp_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      s16c_pkg::S_CLEAR: if (clr_q == 16'hFFFF) state_d = s16c_pkg::S_IDLE;
      s16c_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.command)
            s16c_pkg::CMD_WRITE: state_d = s16c_pkg::S_DONE;
            s16c_pkg::CMD_READ:  state_d = s16c_pkg::S_MEMRD;
            s16c_pkg::CMD_REG:   state_d = s16c_pkg::S_REGRD;
            default: state_d = (halt_q || frz_q != '0) ? s16c_pkg::S_DONE
                                                       : s16c_pkg::S_FETCH;
          endcase
        end
      end
      s16c_pkg::S_MEMRD, s16c_pkg::S_REGRD: state_d = s16c_pkg::S_DONE;
      s16c_pkg::S_FETCH: if (cnt_q == 5'd5) state_d = s16c_pkg::S_OPA;
      s16c_pkg::S_OPA:   state_d = s16c_pkg::S_OPB;
      s16c_pkg::S_OPB:   state_d = s16c_pkg::S_OPC;
      s16c_pkg::S_OPC:   state_d = s16c_pkg::S_EXEC;
      s16c_pkg::S_EXEC:
        state_d = (op == s16c_pkg::OP_DIV) ? s16c_pkg::S_DIV : s16c_pkg::S_MRD;
      s16c_pkg::S_DIV:   if (cnt_q == 5'd15) state_d = s16c_pkg::S_MRD;
      s16c_pkg::S_MRD:   if (cnt_q == {3'd0, nrd}) state_d = s16c_pkg::S_MWR;
      s16c_pkg::S_MWR:   if (cnt_q == {3'd0, nwr}) state_d = s16c_pkg::S_WB;
      s16c_pkg::S_WB:    state_d = s16c_pkg::S_WB2;
      s16c_pkg::S_WB2:   state_d = s16c_pkg::S_FIN;
      s16c_pkg::S_FIN:   state_d = s16c_pkg::S_DONE;
      s16c_pkg::S_DONE:  if (!out_vld_q || !out_stall_i) state_d = s16c_pkg::S_IDLE;
      default:           state_d = s16c_pkg::S_IDLE;
    endcase
  end

  assign cnt_d = (state_d != state_q) ? '0 : cnt_q + 5'd1;

  // outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != s16c_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = wr_data;
    mem_raddr = '0;
    rf_rd_idx = opa;
    rw_en  = 1'b0;
    rw_idx = wb_idx;
    rw_val = wb_val;
    unique case (state_q)
      s16c_pkg::S_CLEAR: begin
        mem_we = 1'b1; mem_waddr = clr_q; mem_wdata = '0;
      end
      s16c_pkg::S_IDLE: begin
        mem_we = acc && (in_item_i.command == s16c_pkg::CMD_WRITE);
        mem_waddr = in_item_i.address;
        mem_wdata = in_item_i.write_byte;
        mem_raddr = in_item_i.address;
        rf_rd_idx = in_item_i.address;
      end
      s16c_pkg::S_FETCH: mem_raddr = pc_q + {11'd0, cnt_q};
      s16c_pkg::S_OPB:   rf_rd_idx = opb;
      s16c_pkg::S_MRD:   mem_raddr = rd_addr;
      s16c_pkg::S_MWR:   mem_we = (cnt_q < {3'd0, nwr});
      s16c_pkg::S_WB:    rw_en = wb_en;
      s16c_pkg::S_WB2: begin
        rw_en = (op == s16c_pkg::OP_XCHG); rw_idx = opb; rw_val = va_q;
      end
      default: begin
      end
    endcase
  end

  assign rf_off = rf_rd_idx - s16c_pkg::FIRST_RAM_REG;
  assign rw_off = rw_idx - s16c_pkg::FIRST_RAM_REG;
  assign rw_ram = rw_en && rw_idx >= s16c_pkg::FIRST_RAM_REG && rw_idx < NREGS;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= s16c_pkg::S_CLEAR;
      cnt_q     <= '0;
      clr_q     <= '0;
      pc_q      <= '0;
      sp_q      <= s16c_pkg::SP_RESET;
      flags_q   <= '0;
      frz_q     <= '0;
      halt_q    <= 1'b0;
      rf_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == s16c_pkg::S_CLEAR) clr_q <= clr_q + 16'd1;
      if (acc && in_item_i.command == s16c_pkg::CMD_RUN && !halt_q && frz_q != '0) begin
        frz_q <= frz_q - 16'd1;
      end
      if (state_q == s16c_pkg::S_EXEC) begin
        case (op)
          s16c_pkg::OP_CMP: begin
            flags_q[2:0] <= {cmp_diff[15], va_q < vb_q, cmp_diff == '0};
          end
          s16c_pkg::OP_TJF:   flags_q[s16c_pkg::FLAG_REL] <= !flags_q[s16c_pkg::FLAG_REL];
          s16c_pkg::OP_HLT:   halt_q <= 1'b1;
          s16c_pkg::OP_WAIT:  frz_q <= va_q;
          s16c_pkg::OP_WAITI: frz_q <= opa;
          default: ;
        endcase
      end
      if (rw_en) begin
        if (rw_idx == s16c_pkg::IDX_PC) pc_q <= rw_val;
        if (rw_idx == s16c_pkg::IDX_SP) sp_q <= rw_val;
        if (rw_idx == s16c_pkg::IDX_FLAGS) flags_q <= rw_val;
      end
      if (rw_ram) rf_vld_q[rw_off[RFW-1:0]] <= 1'b1;
      if (state_q == s16c_pkg::S_FIN) begin
        pc_q <= pc_fin;
        sp_q <= sp_fin;
      end
      if (state_q == s16c_pkg::S_DONE && state_d == s16c_pkg::S_IDLE) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) sp_q <= cfg_data_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rf_idx_q <= rf_rd_idx;
    if (acc) rdat_q <= '0;
    if (state_q == s16c_pkg::S_MEMRD) rdat_q <= {8'd0, mem_rdata};
    if (state_q == s16c_pkg::S_REGRD) rdat_q <= rd_val;
    if (state_q == s16c_pkg::S_FETCH && cnt_q != '0) ins_q <= {ins_q[31:0], mem_rdata};
    if (state_q == s16c_pkg::S_OPB) va_q <= rd_val;
    if (state_q == s16c_pkg::S_OPC) vb_q <= rd_val;
    if (state_q == s16c_pkg::S_EXEC) begin
      res_q <= alu_res;
      rem_q <= '0;
      rdw_q <= '0;
    end
    // restoring divide, one quotient bit per cycle
    if (state_q == s16c_pkg::S_DIV) begin
      if (trial >= {1'b0, vb_q}) begin
        rem_q <= 16'(trial - {1'b0, vb_q});
        res_q <= {res_q[14:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        res_q <= {res_q[14:0], 1'b0};
      end
    end
    if (state_q == s16c_pkg::S_MRD && cnt_q != '0) rdw_q <= {rdw_q[7:0], mem_rdata};
    if (state_q == s16c_pkg::S_DONE && state_d == s16c_pkg::S_IDLE) begin
      out_q.read_data       <= rdat_q;
      out_q.program_counter <= pc_q;
      out_q.halted          <= halt_q;
      out_q.frozen          <= (frz_q != '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag dropped");

  a_vld_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((~rf_vld_q & $past(rf_vld_q)) == '0)) else $error("register valid bit cleared");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s16c_pkg::S_FETCH) |-> (cnt_q <= 5'd5)) else $error("fetch overrun");

  a_freeze_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item_i.command == s16c_pkg::CMD_RUN && !halt_q && frz_q != '0)
    |=> (frz_q == $past(frz_q) - 16'd1)) else $error("freeze count not decremented");

endmodule
